// File: rtl/core/epsc_pkg.sv
`default_nettype none

package epsc_pkg;

    // Lengths in seconds of the periods that the converter takes off one at a time.
    localparam logic [31:0] SecYear     = 32'd31536000;
    localparam logic [31:0] SecLeapYear = 32'd31622400;
    localparam logic [31:0] SecMonth31  = 32'd2678400;
    localparam logic [31:0] SecMonth30  = 32'd2592000;
    localparam logic [31:0] SecMonth29  = 32'd2505600;
    localparam logic [31:0] SecMonth28  = 32'd2419200;
    localparam logic [31:0] SecTenDays  = 32'd864000;
    localparam logic [31:0] SecDay      = 32'd86400;
    localparam logic [31:0] SecTenHours = 32'd36000;
    localparam logic [31:0] SecHour     = 32'd3600;
    localparam logic [31:0] SecTenMins  = 32'd600;
    localparam logic [31:0] SecMinute   = 32'd60;

    // Start values: 1970-01-01 was a Thursday.
    localparam logic [7:0] EpochYear    = 8'd70;
    localparam logic [2:0] EpochWeekday = 3'd4;
    localparam logic [7:0] NonLeapCent  = 8'd200;

    // Sequencer states: idle, done and one per kind of period that is taken off.
    typedef enum logic [3:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_DAY10,
        S_DAY1,
        S_HOUR10,
        S_HOUR1,
        S_MIN10,
        S_MIN1,
        S_DONE
    } t_state;

    // Control from the sequencer to the shared subtract unit.
    typedef struct packed {
        logic        load;
        logic        sub;
        logic [31:0] step;
    } t_unit_ctrl;

    // Status from the shared subtract unit.
    typedef struct packed {
        logic ge;
    } t_unit_stat;

    // Calendar fields built up by the sequencer.
    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] mday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] wday;
    } t_fields;

    // Leap rule on years 1970..2106 counted from 1900; 2000 is leap, 2100 is not.
    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'd0) && (y != NonLeapCent);
    endfunction

    // Length of a month in seconds.
    function automatic logic [31:0] month_seconds(input logic [3:0] m, input logic leap);
        logic [31:0] s;
        s = SecMonth31;
        case (m)
            4'd1:                s = leap ? SecMonth29 : SecMonth28;
            4'd3, 4'd5, 4'd8, 4'd10: s = SecMonth30;
            default:             s = SecMonth31;
        endcase
        return s;
    endfunction

    // Weekday advance of a month: its length modulo 7.
    function automatic logic [1:0] month_wday_inc(input logic [3:0] m, input logic leap);
        logic [1:0] d;
        d = 2'd3;
        case (m)
            4'd1:                d = leap ? 2'd1 : 2'd0;
            4'd3, 4'd5, 4'd8, 4'd10: d = 2'd2;
            default:             d = 2'd3;
        endcase
        return d;
    endfunction

    // Weekday plus a small step, modulo 7.
    function automatic logic [2:0] wday_add(input logic [2:0] w, input logic [1:0] inc);
        logic [3:0] s;
        s = {1'b0, w} + {2'b00, inc};
        return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/epoch_seconds_to_calendar_core.sv
`default_nettype none

// The conversion time is set by the year phase, which takes off one whole year per step, and
// by the month, day, hour and minute phases of the one shared 32-bit subtract and compare unit.
// Throughput: one beat at a time; busy is high from the cycle after acceptance until the
// strobe cycle, in which the next beat may already be accepted.
// The result is shown for exactly one cycle with o_valid; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and clears o_valid.
module epoch_seconds_to_calendar_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_valid,
    output logic [7:0]       o_year_since_1900,
    output logic [3:0]       o_month_index,
    output logic [4:0]       o_day_of_month,
    output logic [4:0]       o_hour_of_day,
    output logic [5:0]       o_minute_of_hour,
    output logic [5:0]       o_second_of_minute,
    output logic [2:0]       o_day_of_week
);

    epsc_pkg::t_unit_ctrl ctrl;
    epsc_pkg::t_unit_stat stat;
    epsc_pkg::t_fields    fields;
    logic [31:0]          rem;
    logic                 done;

    logic                 r_valid;
    epsc_pkg::t_fields    r_fields;
    logic [5:0]           r_second;

    epsc_sub_unit u_sub (
        .i_clk   (i_clk),
        .i_value (i_epoch_seconds),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .o_rem   (rem)
    );

    epsc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_ctrl   (ctrl),
        .o_fields (fields),
        .o_busy   (busy),
        .o_done   (done)
    );

    // Result register; what is left of the count is below one minute at completion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_fields <= fields;
            r_second <= rem[5:0];
        end
    end

    assign o_valid            = r_valid;
    assign o_year_since_1900  = r_fields.year;
    assign o_month_index      = r_fields.month;
    assign o_day_of_month     = r_fields.mday;
    assign o_hour_of_day      = r_fields.hour;
    assign o_minute_of_hour   = r_fields.minute;
    assign o_second_of_minute = r_second;
    assign o_day_of_week      = r_fields.wday;

endmodule

`default_nettype wire

// File: rtl/core/epsc_sub_unit.sv
`default_nettype none

module epsc_sub_unit (
    input  wire logic                  i_clk,
    input  wire logic [31:0]           i_value,
    input  wire epsc_pkg::t_unit_ctrl  i_ctrl,
    output epsc_pkg::t_unit_stat       o_stat,
    output logic [31:0]                o_rem
);

    logic [31:0] r_rem;
    logic [31:0] n_rem;
    logic [32:0] diff;

    // Shared subtractor; the borrow doubles as the compare.
    assign diff        = {1'b0, r_rem} - {1'b0, i_ctrl.step};
    assign o_stat.ge   = ~diff[32];
    assign o_rem       = r_rem;

    // Remainder takes the new count on load, else loses one period when it fits.
    always_comb begin
        n_rem = r_rem;
        if (i_ctrl.load) begin
            n_rem = i_value;
        end else if (i_ctrl.sub && o_stat.ge) begin
            n_rem = diff[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

endmodule

`default_nettype wire

// File: rtl/core/epsc_seq.sv
`default_nettype none

module epsc_seq (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire epsc_pkg::t_unit_stat  i_stat,
    output epsc_pkg::t_unit_ctrl       o_ctrl,
    output epsc_pkg::t_fields          o_fields,
    output logic                       o_busy,
    output logic                       o_done
);

    epsc_pkg::t_state  r_state;
    epsc_pkg::t_state  n_state;
    epsc_pkg::t_fields r_f;
    epsc_pkg::t_fields n_f;
    logic              leap;

    assign leap     = epsc_pkg::is_leap(r_f.year);
    assign o_fields = r_f;

    // Next state: each phase repeats while its period still fits.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            epsc_pkg::S_IDLE:   if (i_start)     n_state = epsc_pkg::S_YEAR;
            epsc_pkg::S_YEAR:   if (!i_stat.ge)  n_state = epsc_pkg::S_MONTH;
            epsc_pkg::S_MONTH:  if (!i_stat.ge)  n_state = epsc_pkg::S_DAY10;
            epsc_pkg::S_DAY10:  if (!i_stat.ge)  n_state = epsc_pkg::S_DAY1;
            epsc_pkg::S_DAY1:   if (!i_stat.ge)  n_state = epsc_pkg::S_HOUR10;
            epsc_pkg::S_HOUR10: if (!i_stat.ge)  n_state = epsc_pkg::S_HOUR1;
            epsc_pkg::S_HOUR1:  if (!i_stat.ge)  n_state = epsc_pkg::S_MIN10;
            epsc_pkg::S_MIN10:  if (!i_stat.ge)  n_state = epsc_pkg::S_MIN1;
            epsc_pkg::S_MIN1:   if (!i_stat.ge)  n_state = epsc_pkg::S_DONE;
            epsc_pkg::S_DONE:   n_state = epsc_pkg::S_IDLE;
            default:            n_state = epsc_pkg::S_IDLE;
        endcase
    end

    // Outputs: unit control, busy, done and the period length of the current phase.
    always_comb begin
        o_ctrl.load = 1'b0;
        o_ctrl.sub  = 1'b1;
        o_ctrl.step = '0;
        o_busy      = 1'b1;
        o_done      = 1'b0;
        unique case (r_state)
            epsc_pkg::S_IDLE: begin
                o_ctrl.load = i_start;
                o_ctrl.sub  = 1'b0;
                o_busy      = 1'b0;
            end
            epsc_pkg::S_YEAR:   o_ctrl.step = leap ? epsc_pkg::SecLeapYear : epsc_pkg::SecYear;
            epsc_pkg::S_MONTH:  o_ctrl.step = epsc_pkg::month_seconds(r_f.month, leap);
            epsc_pkg::S_DAY10:  o_ctrl.step = epsc_pkg::SecTenDays;
            epsc_pkg::S_DAY1:   o_ctrl.step = epsc_pkg::SecDay;
            epsc_pkg::S_HOUR10: o_ctrl.step = epsc_pkg::SecTenHours;
            epsc_pkg::S_HOUR1:  o_ctrl.step = epsc_pkg::SecHour;
            epsc_pkg::S_MIN10:  o_ctrl.step = epsc_pkg::SecTenMins;
            epsc_pkg::S_MIN1:   o_ctrl.step = epsc_pkg::SecMinute;
            epsc_pkg::S_DONE: begin
                o_ctrl.sub = 1'b0;
                o_done     = 1'b1;
            end
            default: o_ctrl.sub = 1'b0;
        endcase
    end

    // Field counters advance with every period taken off; the weekday follows along.
    always_comb begin
        n_f = r_f;
        unique case (r_state)
            epsc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_f.year   = epsc_pkg::EpochYear;
                    n_f.month  = '0;
                    n_f.mday   = 5'd1;
                    n_f.hour   = '0;
                    n_f.minute = '0;
                    n_f.wday   = epsc_pkg::EpochWeekday;
                end
            end
            epsc_pkg::S_YEAR: begin
                if (i_stat.ge) begin
                    n_f.year = r_f.year + 8'd1;
                    n_f.wday = epsc_pkg::wday_add(r_f.wday, leap ? 2'd2 : 2'd1);
                end
            end
            epsc_pkg::S_MONTH: begin
                if (i_stat.ge) begin
                    n_f.month = r_f.month + 4'd1;
                    n_f.wday  = epsc_pkg::wday_add(r_f.wday,
                                    epsc_pkg::month_wday_inc(r_f.month, leap));
                end
            end
            epsc_pkg::S_DAY10: begin
                if (i_stat.ge) begin
                    n_f.mday = r_f.mday + 5'd10;
                    n_f.wday = epsc_pkg::wday_add(r_f.wday, 2'd3);
                end
            end
            epsc_pkg::S_DAY1: begin
                if (i_stat.ge) begin
                    n_f.mday = r_f.mday + 5'd1;
                    n_f.wday = epsc_pkg::wday_add(r_f.wday, 2'd1);
                end
            end
            epsc_pkg::S_HOUR10: if (i_stat.ge) n_f.hour = r_f.hour + 5'd10;
            epsc_pkg::S_HOUR1:  if (i_stat.ge) n_f.hour = r_f.hour + 5'd1;
            epsc_pkg::S_MIN10:  if (i_stat.ge) n_f.minute = r_f.minute + 6'd10;
            epsc_pkg::S_MIN1:   if (i_stat.ge) n_f.minute = r_f.minute + 6'd1;
            default:            n_f = r_f;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
    end

`ifndef ASSERT_OFF
    // An accepted beat always makes the sequencer busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat did not start the sequencer");

    // Completion lasts one cycle and leads back to idle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !o_busy))
        else $error("done did not return to idle");

    // On completion the fields are in calendar range.
    a_done_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_f.month <= 4'd11 && r_f.mday >= 5'd1 && r_f.mday <= 5'd31
                    && r_f.hour <= 5'd23 && r_f.minute <= 6'd59 && r_f.wday <= 3'd6))
        else $error("calendar field out of range at completion");

    // The year phase never runs past the largest representable year.
    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> (r_f.year >= epsc_pkg::EpochYear && r_f.year <= 8'd206))
        else $error("year counter out of range");
`endif

endmodule

`default_nettype wire

// File: test/epoch_seconds_to_calendar_core_tb.sv
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_core_tb;

    localparam int unsigned SecPerDay  = 86400;
    localparam int unsigned SecPerHour = 3600;
    localparam int          RandomBeats = 1000;
    localparam int          DrainCycles = 250;

    // One calendar result, at the widths of the result ports.
    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] mday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] wday;
    } t_calendar;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        busy;
    logic        o_valid;
    logic [7:0]  o_year_since_1900;
    logic [3:0]  o_month_index;
    logic [4:0]  o_day_of_month;
    logic [4:0]  o_hour_of_day;
    logic [5:0]  o_minute_of_hour;
    logic [5:0]  o_second_of_minute;
    logic [2:0]  o_day_of_week;

    logic [31:0] pending_secs[$];
    t_calendar   calendar_due[$];
    int          beats_sent = 0;
    int          error_count = 0;

    epoch_seconds_to_calendar_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_valid            (o_valid),
        .o_year_since_1900  (o_year_since_1900),
        .o_month_index      (o_month_index),
        .o_day_of_month     (o_day_of_month),
        .o_hour_of_day      (o_hour_of_day),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_second_of_minute (o_second_of_minute),
        .o_day_of_week      (o_day_of_week)
    );

    always #5 i_clk = ~i_clk;

    // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
    function automatic bit gregorian_leap(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // Converts a second count to the calendar date, time of day and weekday.
    function automatic t_calendar epoch_to_calendar(input logic [31:0] secs);
        int unsigned rem;
        int unsigned yr;
        int unsigned span;
        int unsigned yday;
        int unsigned y1;
        int unsigned tod;
        int unsigned mdays[12];
        int          mon;
        bit          leap;
        t_calendar   c;
        rem  = secs;
        yr   = 1970;
        leap = gregorian_leap(yr);
        span = (leap ? 366 : 365) * SecPerDay;
        // Take off whole years.
        while (rem >= span) begin
            rem  = rem - span;
            yr   = yr + 1;
            leap = gregorian_leap(yr);
            span = (leap ? 366 : 365) * SecPerDay;
        end
        // The weekday of January 1st plus the day of the year.
        yday   = rem / SecPerDay;
        y1     = yr - 1;
        c.wday = 3'((y1 + y1 / 4 - y1 / 100 + y1 / 400 + yday + 1) % 7);
        // Take off whole months; the remainder is below one year.
        mdays = '{31, leap ? 29 : 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        mon = 0;
        while (rem >= mdays[mon] * SecPerDay) begin
            rem = rem - mdays[mon] * SecPerDay;
            mon = mon + 1;
        end
        tod      = rem % SecPerDay;
        c.year   = 8'(yr - 1900);
        c.month  = 4'(mon);
        c.mday   = 5'(rem / SecPerDay + 1);
        c.hour   = 5'(tod / SecPerHour);
        c.minute = 6'((tod % SecPerHour) / 60);
        c.second = 6'(tod % 60);
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count = error_count + 1;
    endtask

    // Driver: presents pending beats, holds them while busy and idles now and then.
    // Idling is off for a stretch of beats in the middle of the run.
    always @(posedge i_clk) begin
        bit quiet;
        quiet = (beats_sent >= 300) && (beats_sent < 550);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                calendar_due.push_back(epoch_to_calendar(i_epoch_seconds));
                beats_sent = beats_sent + 1;
            end
            if (!start || !busy) begin
                if (pending_secs.size() != 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
                    start           <= 1'b1;
                    i_epoch_seconds <= pending_secs.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest expected date.
    always @(posedge i_clk) begin
        t_calendar   want;
        int unsigned got_f[7];
        int unsigned want_f[7];
        string       names[7];
        if (i_rst_n && o_valid) begin
            if (calendar_due.size() == 0) begin
                report_mismatch("result beat with no input pending");
            end else begin
                want   = calendar_due.pop_front();
                names  = '{"year", "month", "mday", "hour", "minute", "second", "wday"};
                got_f  = '{o_year_since_1900, o_month_index, o_day_of_month, o_hour_of_day,
                           o_minute_of_hour, o_second_of_minute, o_day_of_week};
                want_f = '{want.year, want.month, want.mday, want.hour,
                           want.minute, want.second, want.wday};
                for (int k = 0; k < 7; k++) begin
                    if (got_f[k] != want_f[k]) begin
                        report_mismatch($sformatf("%s got %0d expected %0d",
                                                  names[k], got_f[k], want_f[k]));
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int pick;
        // Edges of the fields, year and leap-day boundaries, the signed range edge
        // and the largest count.
        pending_secs = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                         32'd86400, 32'd31535999, 32'd31536000, 32'd68169600,
                         32'd946684799, 32'd946684800, 32'd951782400, 32'd978307199,
                         32'd2147483647, 32'd2147483648, 32'd4102444799,
                         32'd4107456000, 32'd4107542400, 32'd4291747200,
                         32'hAAAAAAAA, 32'h55555555, 32'd4294967295};
        // Mostly uniform counts, some near the start and some near the top.
        for (int n = 0; n < RandomBeats; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pending_secs.push_back($urandom);
            end else if (pick < 85) begin
                pending_secs.push_back($urandom_range(0, 200000000));
            end else begin
                pending_secs.push_back(32'hFFFFFFFF - $urandom_range(0, 40000000));
            end
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_secs.size() != 0 || start || calendar_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (calendar_due.size() != 0) begin
            report_mismatch("expected results left over");
        end
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
